### hw/rtl/rrsg_pkg.sv
// Package for the rounded rectangle span generator.
// Holds the widths, the radius limit, the datapath command codes and the status struct.
// It has no dependencies.
package rrsg_pkg;

  localparam int CoordBits  = 16;
  localparam int RadBits    = 5;
  localparam int BudgetBits = 6;
  localparam int MaxRadius  = 31;
  localparam int SqBits     = 2 * RadBits;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_CALC_N,
    OP_INC_K,
    OP_DEC_K,
    OP_ARC_TOP,
    OP_ARC_BOT,
    OP_MID,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    logic invalid_req;
    logic zero_radius;
    logic r_zero;
    logic k_up;
    logic k_down;
    logic width_ok;
    logic mid_needed;
    logic budget_hit;
    logic emit_blocked;
    logic out_free;
    logic pend_valid;
    logic top_last;
    logic bot_last;
  } dp_status_t;

endpackage

### hw/rtl/rrsg_datapath.sv
// Datapath of the rounded rectangle span generator: request registers, arc root tracking,
// span formation, the pending span and the output register.
// Depends on rrsg_pkg.
module rrsg_datapath
  import rrsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_op_t                op,
  output dp_status_t            status,
  input  logic [CoordBits-1:0]  in_rect_width,
  input  logic [CoordBits-1:0]  in_rect_height,
  input  logic [RadBits-1:0]    in_corner_radius,
  input  logic [BudgetBits-1:0] in_rect_budget,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RadBits-1:0]    out_span_x,
  output logic [CoordBits-1:0]  out_span_y,
  output logic [CoordBits-1:0]  out_span_width,
  output logic [CoordBits-1:0]  out_span_height,
  output logic                  out_is_empty,
  output logic                  out_is_last
);

  logic [CoordBits-1:0]  width_r;
  logic [CoordBits-1:0]  height_r;
  logic [BudgetBits-1:0] budget_r;
  logic [BudgetBits-1:0] count_r;
  logic [RadBits-1:0]    r_r;
  logic [SqBits-1:0]     r_sq_r;
  logic [RadBits-1:0]    dy_r;
  logic [SqBits-1:0]     n_r;
  logic [RadBits-1:0]    k_r;
  logic [CoordBits-1:0]  row_r;

  logic                  pend_valid_r;
  logic                  pend_empty_r;
  logic [RadBits-1:0]    pend_x_r;
  logic [CoordBits-1:0]  pend_y_r;
  logic [CoordBits-1:0]  pend_w_r;
  logic [CoordBits-1:0]  pend_h_r;

  logic                  out_valid_r;
  logic                  out_empty_r;
  logic                  out_last_r;
  logic [RadBits-1:0]    out_x_r;
  logic [CoordBits-1:0]  out_y_r;
  logic [CoordBits-1:0]  out_w_r;
  logic [CoordBits-1:0]  out_h_r;

  logic [RadBits-1:0]    r_clamp;
  logic [CoordBits-1:0]  half_w;
  logic [CoordBits-1:0]  half_h;
  logic [RadBits-1:0]    inset;
  logic [CoordBits:0]    inset2;
  logic [CoordBits-1:0]  arc_w;
  logic [CoordBits:0]    two_r;
  logic [CoordBits-1:0]  mid_h;
  logic [SqBits-1:0]     dy_sq;
  logic [RadBits:0]      kp1;
  logic [RadBits-1:0]    km1;
  logic [SqBits+1:0]     prod_up;
  logic [SqBits+1:0]     prod_dn;
  logic                  out_free;

  logic                  push_en;
  logic [RadBits-1:0]    push_x;
  logic [CoordBits-1:0]  push_y;
  logic [CoordBits-1:0]  push_w;
  logic [CoordBits-1:0]  push_h;

  always_comb begin
    half_w  = in_rect_width >> 1;
    half_h  = in_rect_height >> 1;
    r_clamp = in_corner_radius;
    if (RadBits'(MaxRadius) < r_clamp) begin
      r_clamp = RadBits'(MaxRadius);
    end
    if (CoordBits'(r_clamp) > half_w) begin
      r_clamp = half_w[RadBits-1:0];
    end
    if (CoordBits'(r_clamp) > half_h) begin
      r_clamp = half_h[RadBits-1:0];
    end

    inset   = r_r - k_r;
    inset2  = (CoordBits+1)'({inset, 1'b0});
    arc_w   = width_r - inset2[CoordBits-1:0];
    two_r   = (CoordBits+1)'({r_r, 1'b0});
    mid_h   = height_r - two_r[CoordBits-1:0];
    dy_sq   = SqBits'(dy_r) * SqBits'(dy_r);
    kp1     = (RadBits+1)'(k_r) + (RadBits+1)'(1);
    km1     = k_r - RadBits'(1);
    prod_up = (SqBits+2)'(kp1) * (SqBits+2)'(k_r);
    prod_dn = (SqBits+2)'(k_r) * (SqBits+2)'(km1);
    out_free = !out_valid_r || out_ready;

    status.invalid_req  = (in_rect_width == '0) || (in_rect_height == '0) ||
                          (in_rect_budget == '0);
    status.zero_radius  = (in_corner_radius == '0);
    status.r_zero       = (r_r == '0);
    status.k_up         = prod_up < (SqBits+2)'(n_r);
    status.k_down       = (k_r != '0) && (prod_dn >= (SqBits+2)'(n_r));
    status.width_ok     = {1'b0, width_r} > inset2;
    status.mid_needed   = {1'b0, height_r} > two_r;
    status.budget_hit   = (count_r == budget_r);
    status.emit_blocked = pend_valid_r && !out_free;
    status.out_free     = out_free;
    status.pend_valid   = pend_valid_r;
    status.top_last     = (dy_r == RadBits'(1));
    status.bot_last     = (dy_r == r_r);

    push_en = 1'b0;
    push_x  = inset;
    push_y  = row_r;
    push_w  = arc_w;
    push_h  = CoordBits'(1);
    case (op)
      OP_ARC_TOP, OP_ARC_BOT: begin
        push_en = status.width_ok;
      end
      OP_MID: begin
        push_en = status.mid_needed;
        push_x  = '0;
        push_y  = CoordBits'(r_r);
        push_w  = width_r;
        push_h  = mid_h;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      count_r      <= '0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          width_r  <= in_rect_width;
          height_r <= in_rect_height;
          budget_r <= in_rect_budget;
          r_r      <= r_clamp;
          count_r  <= '0;
          pend_x_r <= '0;
          if (status.invalid_req) begin
            pend_valid_r <= 1'b1;
            pend_empty_r <= 1'b1;
            pend_y_r     <= '0;
            pend_w_r     <= '0;
            pend_h_r     <= '0;
          end else if (status.zero_radius) begin
            pend_valid_r <= 1'b1;
            pend_empty_r <= 1'b0;
            pend_y_r     <= '0;
            pend_w_r     <= in_rect_width;
            pend_h_r     <= in_rect_height;
            count_r      <= BudgetBits'(1);
          end
        end
        OP_SETUP: begin
          r_sq_r <= SqBits'(r_r) * SqBits'(r_r);
          dy_r   <= r_r;
          row_r  <= '0;
          k_r    <= '0;
        end
        OP_CALC_N: begin
          n_r <= r_sq_r - dy_sq;
        end
        OP_INC_K: begin
          k_r <= kp1[RadBits-1:0];
        end
        OP_DEC_K: begin
          k_r <= km1;
        end
        OP_ARC_TOP: begin
          dy_r  <= dy_r - RadBits'(1);
          row_r <= row_r + CoordBits'(1);
        end
        OP_ARC_BOT: begin
          dy_r  <= dy_r + RadBits'(1);
          row_r <= row_r + CoordBits'(1);
        end
        OP_MID: begin
          dy_r  <= RadBits'(1);
          row_r <= height_r - CoordBits'(r_r);
        end
        OP_FLUSH: begin
          out_valid_r  <= 1'b1;
          out_last_r   <= 1'b1;
          out_empty_r  <= pend_empty_r;
          out_x_r      <= pend_x_r;
          out_y_r      <= pend_y_r;
          out_w_r      <= pend_w_r;
          out_h_r      <= pend_h_r;
          pend_valid_r <= 1'b0;
        end
        default: begin
        end
      endcase
      if (push_en) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b0;
          out_empty_r <= pend_empty_r;
          out_x_r     <= pend_x_r;
          out_y_r     <= pend_y_r;
          out_w_r     <= pend_w_r;
          out_h_r     <= pend_h_r;
        end
        pend_valid_r <= 1'b1;
        pend_empty_r <= 1'b0;
        pend_x_r     <= push_x;
        pend_y_r     <= push_y;
        pend_w_r     <= push_w;
        pend_h_r     <= push_h;
        count_r      <= count_r + BudgetBits'(1);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_span_x      = out_x_r;
  assign out_span_y      = out_y_r;
  assign out_span_width  = out_w_r;
  assign out_span_height = out_h_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_last     = out_last_r;

endmodule

### hw/rtl/rrsg_controller.sv
// Controller of the rounded rectangle span generator: sequences the top arc, the middle
// block, the bottom arc and the final transfer.
// Depends on rrsg_pkg.
module rrsg_controller
  import rrsg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_TOP_N,
    S_TOP_K,
    S_MID,
    S_BOT_N,
    S_BOT_K,
    S_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    op        = OP_NONE;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (status.invalid_req || status.zero_radius) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        op        = OP_SETUP;
        state_nxt = status.r_zero ? S_MID : S_TOP_N;
      end
      S_TOP_N: begin
        op        = OP_CALC_N;
        state_nxt = S_TOP_K;
      end
      S_TOP_K: begin
        if (status.k_up) begin
          op = OP_INC_K;
        end else if (status.width_ok && status.budget_hit) begin
          state_nxt = S_FLUSH;
        end else if (!(status.width_ok && status.emit_blocked)) begin
          op        = OP_ARC_TOP;
          state_nxt = status.top_last ? S_MID : S_TOP_N;
        end
      end
      S_MID: begin
        if (status.mid_needed && status.budget_hit) begin
          state_nxt = S_FLUSH;
        end else if (!(status.mid_needed && status.emit_blocked)) begin
          op        = OP_MID;
          state_nxt = status.r_zero ? S_FLUSH : S_BOT_N;
        end
      end
      S_BOT_N: begin
        op        = OP_CALC_N;
        state_nxt = S_BOT_K;
      end
      S_BOT_K: begin
        if (status.k_down) begin
          op = OP_DEC_K;
        end else if (status.width_ok && status.budget_hit) begin
          state_nxt = S_FLUSH;
        end else if (!(status.width_ok && status.emit_blocked)) begin
          op        = OP_ARC_BOT;
          state_nxt = status.bot_last ? S_FLUSH : S_BOT_N;
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          op        = OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/rounded_rect_span_generator.sv
// Top level of the rounded rectangle span generator.
// Joins rrsg_controller and rrsg_datapath; depends on rrsg_pkg.
//
//   Channel   Direction  Handshake            Payload
//   in_*      input      in_valid/in_ready    rect_width, rect_height, corner_radius, rect_budget
//   out_*     output     out_valid/out_ready  span_x/y/width/height, is_empty, is_last
//
// One request at a time. For clamped radius r a request runs through load, setup, the top arc
// rows (each computes its radicand, tracks the rounded square root one increment per cycle
// and forms its span), the middle block, the bottom arc rows and the final transfer. An invalid
// or zero radius request goes from load to the final transfer; a budget cut-off ends it early.
// Each span is held one step in a pending register so that the last one can be flagged.
// Reset (synchronous, active low) returns the controller to idle and empties both registers.
// A stalled output register holds the sequence; a new request is taken while the final
// transfer of the previous one still waits.
module rounded_rect_span_generator
  import rrsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CoordBits-1:0]  in_rect_width,
  input  logic [CoordBits-1:0]  in_rect_height,
  input  logic [RadBits-1:0]    in_corner_radius,
  input  logic [BudgetBits-1:0] in_rect_budget,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RadBits-1:0]    out_span_x,
  output logic [CoordBits-1:0]  out_span_y,
  output logic [CoordBits-1:0]  out_span_width,
  output logic [CoordBits-1:0]  out_span_height,
  output logic                  out_is_empty,
  output logic                  out_is_last
);

  dp_op_t     op;
  dp_status_t status;

  rrsg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  rrsg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .status           (status),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_corner_radius (in_corner_radius),
    .in_rect_budget   (in_rect_budget),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_x       (out_span_x),
    .out_span_y       (out_span_y),
    .out_span_width   (out_span_width),
    .out_span_height  (out_span_height),
    .out_is_empty     (out_is_empty),
    .out_is_last      (out_is_last)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for rounded_rect_span_generator.
// Drives span requests through valid/ready, predicts the rectangle list of each one and
// compares every result transfer in order; depends on rrsg_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
  import rrsg_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 4 * MaxRadius + 40;

  typedef struct packed {
    logic [RadBits-1:0]   x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] w;
    logic [CoordBits-1:0] h;
    logic                 empty;
    logic                 last;
  } span_t;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_SPARSE,
    SINK_MIXED
  } sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CoordBits-1:0]  in_rect_width = '0;
  logic [CoordBits-1:0]  in_rect_height = '0;
  logic [RadBits-1:0]    in_corner_radius = '0;
  logic [BudgetBits-1:0] in_rect_budget = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RadBits-1:0]    out_span_x;
  logic [CoordBits-1:0]  out_span_y;
  logic [CoordBits-1:0]  out_span_width;
  logic [CoordBits-1:0]  out_span_height;
  logic                  out_is_empty;
  logic                  out_is_last;

  span_t       expected_spans[$];
  int unsigned span_room;
  int unsigned error_count = 0;
  int unsigned requests_taken = 0;
  int unsigned spans_checked = 0;
  int unsigned cycle_count = 0;

  sink_mode_t  sink_mode = SINK_ALWAYS;
  int unsigned sink_phase = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  bit          gaps_on = 1'b0;
  int unsigned burst_left = 0;

  rounded_rect_span_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_corner_radius (in_corner_radius),
    .in_rect_budget   (in_rect_budget),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_x       (out_span_x),
    .out_span_y       (out_span_y),
    .out_span_width   (out_span_width),
    .out_span_height  (out_span_height),
    .out_is_empty     (out_is_empty),
    .out_is_last      (out_is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d spans still expected", $time,
               cycle_count, expected_spans.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void add_span(input int unsigned x, input int unsigned y,
                                   input int unsigned wd, input int unsigned ht);
    span_t s;
    if (span_room == 0) begin
      return;
    end
    s.x = x[RadBits-1:0];
    s.y = y[CoordBits-1:0];
    s.w = wd[CoordBits-1:0];
    s.h = ht[CoordBits-1:0];
    s.empty = 1'b0;
    s.last = 1'b0;
    expected_spans.push_back(s);
    span_room--;
  endfunction

  function automatic void add_arc_row(input int unsigned wd, input int unsigned r,
                                      input int unsigned dy, input int unsigned row);
    int unsigned n;
    int unsigned k;
    int unsigned inset;
    n = r * r - dy * dy;
    k = 0;
    while ((k + 1) * k < n) begin
      k++;
    end
    if (k > r) begin
      k = r;
    end
    inset = r - k;
    if (wd <= 2 * inset) begin
      return;
    end
    add_span(inset, row, wd - 2 * inset, 1);
  endfunction

  function automatic void predict_spans(input logic [CoordBits-1:0] wd,
                                        input logic [CoordBits-1:0] ht,
                                        input logic [RadBits-1:0] rad,
                                        input logic [BudgetBits-1:0] budget);
    int unsigned first;
    int unsigned r;
    int unsigned wdi;
    int unsigned hti;
    span_t s;
    first = expected_spans.size();
    wdi = 32'(wd);
    hti = 32'(ht);
    if (wdi == 0 || hti == 0 || budget == '0) begin
      s = '0;
      s.empty = 1'b1;
      s.last = 1'b1;
      expected_spans.push_back(s);
      return;
    end
    span_room = 32'(budget);
    if (rad == '0) begin
      add_span(0, 0, wdi, hti);
    end else begin
      r = 32'(rad);
      if (r > MaxRadius) begin
        r = MaxRadius;
      end
      if (r > wdi / 2) begin
        r = wdi / 2;
      end
      if (r > hti / 2) begin
        r = hti / 2;
      end
      for (int unsigned y = 0; y < r; y++) begin
        add_arc_row(wdi, r, r - y, y);
      end
      if (hti > 2 * r) begin
        add_span(0, r, wdi, hti - 2 * r);
      end
      for (int unsigned y = 0; y < r; y++) begin
        add_arc_row(wdi, r, y + 1, hti - r + y);
      end
    end
    if (expected_spans.size() > first) begin
      s = expected_spans.pop_back();
      s.last = 1'b1;
      expected_spans.push_back(s);
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
      error_count++;
    end
  endfunction

  // Requests are predicted and results are checked in one process, so their order is fixed.
  always @(posedge clk) begin
    span_t exp_span;
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) begin
        predict_spans(in_rect_width, in_rect_height, in_corner_radius, in_rect_budget);
        requests_taken++;
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got x=%0d y=%0d w=%0d h=%0d",
                   $time, out_span_x, out_span_y, out_span_width, out_span_height);
          error_count++;
        end else begin
          exp_span = expected_spans.pop_front();
          check_field("span_x", 32'(exp_span.x), 32'(out_span_x));
          check_field("span_y", 32'(exp_span.y), 32'(out_span_y));
          check_field("span_width", 32'(exp_span.w), 32'(out_span_width));
          check_field("span_height", 32'(exp_span.h), 32'(out_span_height));
          check_field("is_empty", 32'(exp_span.empty), 32'(out_is_empty));
          check_field("is_last", 32'(exp_span.last), 32'(out_is_last));
          spans_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      sink_phase <= sink_phase + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_request != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_request;
        hold_request = 0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: out_ready <= 1'b1;
          SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
          SINK_SPARSE: out_ready <= (sink_phase % 5 == 0) || ($urandom_range(0, 7) == 0);
          default: out_ready <= ((sink_phase / 64) % 2 == 0) ? 1'b1 :
                                ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  task automatic send_request(input logic [CoordBits-1:0] wd,
                              input logic [CoordBits-1:0] ht,
                              input logic [RadBits-1:0] rad,
                              input logic [BudgetBits-1:0] budget);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_rect_width <= wd;
    in_rect_height <= ht;
    in_corner_radius <= rad;
    in_rect_budget <= budget;
    do begin
      @(posedge clk);
    end while (in_ready !== 1'b1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_spans.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [CoordBits-1:0] random_extent(input int unsigned rad);
    int unsigned pick;
    pick = $urandom_range(0, 29);
    if (pick == 0) begin
      return '0;
    end else if (pick <= 3) begin
      return CoordBits'(2 * rad);
    end else if (pick <= 14) begin
      return CoordBits'($urandom_range(1, 80));
    end else if (pick <= 22) begin
      return CoordBits'($urandom_range(1, 400));
    end
    return CoordBits'($urandom_range(1, 65535));
  endfunction

  task automatic send_random_request();
    logic [RadBits-1:0]    rad;
    logic [BudgetBits-1:0] budget;
    rad = RadBits'($urandom_range(0, 31));
    budget = ($urandom_range(0, 24) == 0) ? '0 : BudgetBits'($urandom_range(1, 63));
    send_request(random_extent(32'(rad)), random_extent(32'(rad)), rad, budget);
  endtask

  task automatic test_invalid_requests();
    send_request(16'd0, 16'd50, 5'd4, 6'd10);
    send_request(16'd50, 16'd0, 5'd4, 6'd10);
    send_request(16'd50, 16'd50, 5'd4, 6'd0);
    send_request(16'd0, 16'd0, 5'd0, 6'd0);
  endtask

  task automatic test_zero_radius();
    send_request(16'hFFFF, 16'hFFFF, 5'd0, 6'd63);
    send_request(16'd1, 16'd1, 5'd0, 6'd1);
  endtask

  task automatic test_radius_clamping();
    send_request(16'hFFFF, 16'hFFFF, 5'd31, 6'd63);
    send_request(16'd62, 16'd62, 5'd31, 6'd63);
    send_request(16'd10, 16'd100, 5'd31, 6'd63);
    send_request(16'd100, 16'd10, 5'd31, 6'd40);
    send_request(16'd1, 16'd1, 5'd5, 6'd3);
    send_request(16'hFFFF, 16'd1, 5'd31, 6'd7);
    send_request(16'd3, 16'd3, 5'd31, 6'd63);
  endtask

  task automatic test_budget_limit();
    send_request(16'd200, 16'd200, 5'd20, 6'd1);
    send_request(16'd200, 16'd200, 5'd20, 6'd5);
    send_request(16'd40, 16'd20, 5'd10, 6'd63);
    send_request(16'd40, 16'd40, 5'd20, 6'd21);
  endtask

  task automatic test_random_mixed();
    sink_mode = SINK_MIXED;
    gaps_on = 1'b1;
    repeat (150) send_random_request();
    drain_results();
  endtask

  // The receiver holds off long enough for the block to fill up and stall its input while
  // the sender keeps offering requests back to back.
  task automatic test_backpressure();
    sink_mode = SINK_RANDOM;
    gaps_on = 1'b0;
    hold_request = 400;
    repeat (12) send_random_request();
    drain_results();
  endtask

  task automatic test_streaming();
    sink_mode = SINK_ALWAYS;
    gaps_on = 1'b0;
    repeat (100) send_random_request();
    drain_results();
  endtask

  task automatic test_heavy_stall();
    sink_mode = SINK_SPARSE;
    gaps_on = 1'b1;
    repeat (90) send_random_request();
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_mode = SINK_RANDOM;
    gaps_on = 1'b1;
    test_invalid_requests();
    test_zero_radius();
    test_radius_clamping();
    test_budget_limit();
    drain_results();
    test_random_mixed();
    test_backpressure();
    test_streaming();
    test_heavy_stall();
    $display("Covered %0d requests: invalid, zero and clamped radius, budget cut-off,",
             requests_taken);
    $display("back-pressure and input gaps; %0d span transfers checked, %0d errors.",
             spans_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
